// ----- design/frustum_cull_sphere_box_defines.svh -----
// Assertion macros for the frustum culling block.
// Used by the top level only; depends on nothing else.
`ifndef FRUSTUM_CULL_SPHERE_BOX_DEFINES_SVH
`define FRUSTUM_CULL_SPHERE_BOX_DEFINES_SVH

// same-cycle implication
`define FCSB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FCSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/fcsb_pkg.sv -----
// Shared constants, codes and types of the frustum culling block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fcsb_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_W      = 16;
   localparam int SLOT_W      = 3;
   localparam int FUNC_W      = 2;
   localparam int VERDICT_W   = 2;
   localparam int PIDX_W      = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam int PROD_W      = 2 * COORD_WIDTH;
   localparam int TERM_W      = COORD_WIDTH + 1;
   localparam int SUM_W       = 2 * COORD_WIDTH + 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SPHERE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BOX    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

   localparam logic [VERDICT_W-1:0] VERDICT_INSIDE  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_CROSS   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_SPHERE,
      OP_BOX
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      coord_type           px;
      coord_type           py;
      coord_type           pz;
      coord_type           hx;
      coord_type           hy;
      coord_type           hz;
      coord_type           sc;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DRAIN
   } back_state_type;

endpackage

`default_nettype wire

// ----- design/fcsb_front.sv -----
// Front part: takes request words, decodes the function and drops no-ops
// and loads to absent planes. Depends on fcsb_pkg.
`default_nettype none

module fcsb_front (
   input  logic                         start,
   input  logic                         busy,
   input  logic [fcsb_pkg::FUNC_W-1:0]  req_func,
   input  logic [fcsb_pkg::SLOT_W-1:0]  req_plane_slot,
   input  fcsb_pkg::coord_type          req_point_x,
   input  fcsb_pkg::coord_type          req_point_y,
   input  fcsb_pkg::coord_type          req_point_z,
   input  fcsb_pkg::coord_type          req_far_x,
   input  fcsb_pkg::coord_type          req_far_y,
   input  fcsb_pkg::coord_type          req_far_z,
   input  fcsb_pkg::coord_type          req_scalar,
   output logic                         push,
   output fcsb_pkg::item_type           push_item
);
   import fcsb_pkg::*;

   logic   keep;
   logic   slot_ok;
   op_type op;

   assign slot_ok = {1'b0, req_plane_slot} < (SLOT_W + 1)'(NUM_PLANES);

   always_comb begin
      op   = OP_LOAD;
      keep = 1'b0;
      case (req_func)
         FUNC_LOAD: begin
            op   = OP_LOAD;
            keep = slot_ok;
         end
         FUNC_SPHERE: begin
            op   = OP_SPHERE;
            keep = 1'b1;
         end
         FUNC_BOX: begin
            op   = OP_BOX;
            keep = 1'b1;
         end
         FUNC_NOP: begin
            op   = OP_LOAD;
            keep = 1'b0;
         end
         default: begin
            op   = OP_LOAD;
            keep = 1'b0;
         end
      endcase
   end

   assign push           = start && !busy && keep;
   assign push_item.op   = op;
   assign push_item.slot = req_plane_slot;
   assign push_item.px   = req_point_x;
   assign push_item.py   = req_point_y;
   assign push_item.pz   = req_point_z;
   assign push_item.hx   = req_far_x;
   assign push_item.hy   = req_far_y;
   assign push_item.hz   = req_far_z;
   assign push_item.sc   = req_scalar;

endmodule

`default_nettype wire

// ----- design/fcsb_queue.sv -----
// Short in-order queue of decoded words between the front and back parts.
// Depends on fcsb_pkg.
`default_nettype none

module fcsb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fcsb_pkg::item_type         push_item,
   input  logic                       pop,
   output fcsb_pkg::item_type         head_item,
   output fcsb_pkg::queue_status_type status
);
   import fcsb_pkg::*;

   item_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = q_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ----- design/fcsb_back.sv -----
// Back part: plane store and the per-plane test loop, one plane a cycle
// through six shared multipliers, then a sum and sign stage. Depends on fcsb_pkg.
`default_nettype none

module fcsb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  fcsb_pkg::queue_status_type    status,
   input  fcsb_pkg::item_type            head_item,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [fcsb_pkg::VERDICT_W-1:0] rsp_verdict
);
   import fcsb_pkg::*;

   localparam logic [PIDX_W-1:0] LAST_PLANE = PIDX_W'(NUM_PLANES - 1);
   localparam int PEXT_W = SUM_W - PROD_W;
   localparam int TEXT_W = SUM_W - TERM_W - FRAC_W;

   back_state_type state_ff, state_in;
   logic [PIDX_W-1:0] k_ff, k_in;
   item_type          item_ff, item_in;

   coord_type plane_nx_ff  [NUM_PLANES];
   coord_type plane_ny_ff  [NUM_PLANES];
   coord_type plane_nz_ff  [NUM_PLANES];
   coord_type plane_off_ff [NUM_PLANES];
   logic      store_we;

   logic signed [PROD_W-1:0] pfx_ff, pfx_in, pfy_ff, pfy_in, pfz_ff, pfz_in;
   logic signed [PROD_W-1:0] pnx_ff, pnx_in, pny_ff, pny_in, pnz_ff, pnz_in;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic cmp_v_ff, cmp_v_in;
   logic outside_ff, outside_in;
   logic cross_ff, cross_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff, rsp_verdict_in;

   coord_type nx, ny, nz, off;
   coord_type fx, fy, fz, qx, qy, qz, add;
   logic      box;
   logic [SUM_W-1:0] term_sh, far_sum, near_sum;
   logic             far_behind, near_behind, out_all, cross_all;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!status.empty && (head_item.op != OP_LOAD)) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (k_ff == LAST_PLANE) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop      = 1'b0;
      cmp_v_in = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop = !status.empty;
         end
         BK_RUN: begin
            cmp_v_in = 1'b1;
         end
         BK_DRAIN: begin
            pop = 1'b0;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign store_we = pop && (head_item.op == OP_LOAD);
   assign item_in  = pop ? head_item : item_ff;

   always_comb begin
      k_in = k_ff;
      if (pop) begin
         k_in = '0;
      end else if ((state_ff == BK_RUN) && (k_ff != LAST_PLANE)) begin
         k_in = k_ff + 1'b1;
      end
   end

   // multiply stage: pick corners by normal sign bits
   always_comb begin
      nx  = plane_nx_ff[k_ff];
      ny  = plane_ny_ff[k_ff];
      nz  = plane_nz_ff[k_ff];
      off = plane_off_ff[k_ff];
      box = (item_ff.op == OP_BOX);
      fx  = (box && !nx[COORD_WIDTH-1]) ? item_ff.hx : item_ff.px;
      fy  = (box && !ny[COORD_WIDTH-1]) ? item_ff.hy : item_ff.py;
      fz  = (box && !nz[COORD_WIDTH-1]) ? item_ff.hz : item_ff.pz;
      qx  = nx[COORD_WIDTH-1] ? item_ff.hx : item_ff.px;
      qy  = ny[COORD_WIDTH-1] ? item_ff.hy : item_ff.py;
      qz  = nz[COORD_WIDTH-1] ? item_ff.hz : item_ff.pz;
      add = box ? '0 : item_ff.sc;
      pfx_in  = PROD_W'(fx) * PROD_W'(nx);
      pfy_in  = PROD_W'(fy) * PROD_W'(ny);
      pfz_in  = PROD_W'(fz) * PROD_W'(nz);
      pnx_in  = PROD_W'(qx) * PROD_W'(nx);
      pny_in  = PROD_W'(qy) * PROD_W'(ny);
      pnz_in  = PROD_W'(qz) * PROD_W'(nz);
      term_in = TERM_W'(add) - TERM_W'(off);
   end

   // sum and sign stage
   always_comb begin
      term_sh  = {{TEXT_W{term_ff[TERM_W-1]}}, term_ff, {FRAC_W{1'b0}}};
      far_sum  = {{PEXT_W{pfx_ff[PROD_W-1]}}, pfx_ff}
               + {{PEXT_W{pfy_ff[PROD_W-1]}}, pfy_ff}
               + {{PEXT_W{pfz_ff[PROD_W-1]}}, pfz_ff} + term_sh;
      near_sum = {{PEXT_W{pnx_ff[PROD_W-1]}}, pnx_ff}
               + {{PEXT_W{pny_ff[PROD_W-1]}}, pny_ff}
               + {{PEXT_W{pnz_ff[PROD_W-1]}}, pnz_ff} + term_sh;
      far_behind  = far_sum[SUM_W-1];
      near_behind = near_sum[SUM_W-1];
      out_all     = outside_ff || (cmp_v_ff && far_behind);
      cross_all   = cross_ff || (cmp_v_ff && near_behind);
   end

   always_comb begin
      outside_in = out_all;
      cross_in   = cross_all;
      if (pop) begin
         outside_in = 1'b0;
         cross_in   = 1'b0;
      end
   end

   assign rsp_valid_in = (state_ff == BK_DRAIN);

   always_comb begin
      if (out_all) begin
         rsp_verdict_in = VERDICT_OUTSIDE;
      end else if ((item_ff.op == OP_BOX) && cross_all) begin
         rsp_verdict_in = VERDICT_CROSS;
      end else begin
         rsp_verdict_in = VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         k_ff         <= '0;
         cmp_v_ff     <= 1'b0;
         outside_ff   <= 1'b0;
         cross_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         cmp_v_ff     <= cmp_v_in;
         outside_ff   <= outside_in;
         cross_ff     <= cross_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      pfx_ff         <= pfx_in;
      pfy_ff         <= pfy_in;
      pfz_ff         <= pfz_in;
      pnx_ff         <= pnx_in;
      pny_ff         <= pny_in;
      pnz_ff         <= pnz_in;
      term_ff        <= term_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   // plane store, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_nx_ff[i]  <= '0;
            plane_ny_ff[i]  <= '0;
            plane_nz_ff[i]  <= '0;
            plane_off_ff[i] <= '0;
         end
      end else if (store_we) begin
         plane_nx_ff[head_item.slot[PIDX_W-1:0]]  <= head_item.px;
         plane_ny_ff[head_item.slot[PIDX_W-1:0]]  <= head_item.py;
         plane_nz_ff[head_item.slot[PIDX_W-1:0]]  <= head_item.pz;
         plane_off_ff[head_item.slot[PIDX_W-1:0]] <= head_item.sc;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

`default_nettype wire

// ----- design/frustum_cull_sphere_box.sv -----
// Top level of the frustum culling block: front, queue and back parts.
// Depends on fcsb_pkg, fcsb_front, fcsb_queue, fcsb_back and the defines header.
//
// Usage:
//   Request channel: a word is taken at a rising edge where start is high and
//   busy is low. req_func selects load plane (0), sphere test (1) or box
//   test (2); code 3 and loads to a slot at or past the plane count are dropped.
//   Response channel: rsp_valid marks rsp_verdict for exactly one cycle, one
//   response per sphere or box test, none for loads. The receiver cannot
//   stall, so responses are never held back.
//   Sequencing: the back part pops a test, runs one plane per cycle through
//   the shared multiplier lanes, then forms the final sum and registers the
//   verdict; a load is stored as it is popped. A two-word queue lets the
//   front keep taking words while the back part works.
//   Reset: synchronous, clears the queue, the sequencer and all six planes
//   to zero; busy is high while reset is held.
`default_nettype none

`include "frustum_cull_sphere_box_defines.svh"

module frustum_cull_sphere_box (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fcsb_pkg::FUNC_W-1:0]   req_func,
   input  logic [fcsb_pkg::SLOT_W-1:0]   req_plane_slot,
   input  fcsb_pkg::coord_type           req_point_x,
   input  fcsb_pkg::coord_type           req_point_y,
   input  fcsb_pkg::coord_type           req_point_z,
   input  fcsb_pkg::coord_type           req_far_x,
   input  fcsb_pkg::coord_type           req_far_y,
   input  fcsb_pkg::coord_type           req_far_z,
   input  fcsb_pkg::coord_type           req_scalar,
   output logic                          rsp_valid,
   output logic [fcsb_pkg::VERDICT_W-1:0] rsp_verdict
);
   import fcsb_pkg::*;

   logic             q_push;
   logic             q_pop;
   item_type         q_push_item;
   item_type         q_head_item;
   queue_status_type q_stat;

   assign busy = q_stat.full || reset;

   fcsb_front u_front (
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_plane_slot (req_plane_slot),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_far_x      (req_far_x),
      .req_far_y      (req_far_y),
      .req_far_z      (req_far_z),
      .req_scalar     (req_scalar),
      .push           (q_push),
      .push_item      (q_push_item)
   );

   fcsb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .status    (q_stat)
   );

   fcsb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .status      (q_stat),
      .head_item   (q_head_item),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_verdict (rsp_verdict)
   );

   `FCSB_ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid, !rsp_valid, "responses back to back")
   `FCSB_ASSERT_NOW(a_pop_nonempty, clock, reset, q_pop, !q_stat.empty, "queue popped while empty")
   `FCSB_ASSERT_NOW(a_push_room, clock, reset, q_push, !q_stat.full, "queue pushed while full")
   `FCSB_ASSERT_NOW(a_verdict_code, clock, reset, rsp_valid, (rsp_verdict == VERDICT_INSIDE) || (rsp_verdict == VERDICT_CROSS) || (rsp_verdict == VERDICT_OUTSIDE), "bad verdict code")

endmodule

`default_nettype wire

// ----- tb/sv/frustum_cull_sphere_box_tb.sv -----
// Testbench for frustum_cull_sphere_box: planes, sphere tests and box tests.
// It predicts each verdict from its own copy of the plane store and compares it.
// Depends on fcsb_pkg and the frustum_cull_sphere_box top level.
`timescale 1ns / 1ps

module frustum_cull_sphere_box_tb;
   import fcsb_pkg::*;

   localparam int ITEMS_TARGET = 1400;
   localparam int STALL_LIMIT  = 1000;
   localparam int SETTLE       = 2 * (NUM_PLANES + 3);

   localparam coord_type ONE  = 32'sh0001_0000;
   localparam coord_type CMAX = 32'sh7fff_ffff;
   localparam coord_type CMIN = 32'sh8000_0000;
   localparam logic signed [67:0] Q_ONE = 68'sd65536;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] slot;
      coord_type px, py, pz;
      coord_type hx, hy, hz;
      coord_type sc;
   } cull_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FUNC_W-1:0] req_func = '0;
   logic [SLOT_W-1:0] req_plane_slot = '0;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   coord_type req_point_z = '0;
   coord_type req_far_x = '0;
   coord_type req_far_y = '0;
   coord_type req_far_z = '0;
   coord_type req_scalar = '0;
   logic rsp_valid;
   logic [VERDICT_W-1:0] rsp_verdict;

   coord_type plane_nx [NUM_PLANES];
   coord_type plane_ny [NUM_PLANES];
   coord_type plane_nz [NUM_PLANES];
   coord_type plane_d  [NUM_PLANES];

   logic [VERDICT_W-1:0] verdict_due [$];
   int fails = 0;
   int scored = 0;
   int dropped = 0;
   int n_loads = 0;
   int n_spheres = 0;
   int n_boxes = 0;
   int verdict_seen [3] = '{0, 0, 0};
   int stall_cycles = 0;
   bit gaps_on = 1'b1;

   frustum_cull_sphere_box dut (.*);

   always #5 clock = ~clock;

   function automatic cull_word_type word_of(input logic [FUNC_W-1:0] func,
                                             input logic [SLOT_W-1:0] slot,
                                             input coord_type px, py, pz,
                                             input coord_type hx, hy, hz,
                                             input coord_type sc);
      cull_word_type w;
      w.func = func;
      w.slot = slot;
      w.px = px;
      w.py = py;
      w.pz = pz;
      w.hx = hx;
      w.hy = hy;
      w.hz = hz;
      w.sc = sc;
      return w;
   endfunction

   // dot(p, n) + lift < offset, kept exact in Q36.32
   function automatic bit lies_behind(input int k, input coord_type px, py, pz,
                                      input coord_type lift);
      logic signed [67:0] acc;
      acc = 68'(px) * 68'(plane_nx[k]) + 68'(py) * 68'(plane_ny[k])
            + 68'(pz) * 68'(plane_nz[k])
            + 68'(lift) * Q_ONE - 68'(plane_d[k]) * Q_ONE;
      return acc[67];
   endfunction

   function automatic logic [VERDICT_W-1:0] sphere_verdict(input cull_word_type w);
      for (int k = 0; k < NUM_PLANES; k++) begin
         if (lies_behind(k, w.px, w.py, w.pz, w.sc))
            return VERDICT_OUTSIDE;
      end
      return VERDICT_INSIDE;
   endfunction

   function automatic logic [VERDICT_W-1:0] box_verdict(input cull_word_type w);
      bit crossing;
      bit sx, sy, sz;
      crossing = 1'b0;
      for (int k = 0; k < NUM_PLANES; k++) begin
         sx = plane_nx[k][COORD_WIDTH-1];
         sy = plane_ny[k][COORD_WIDTH-1];
         sz = plane_nz[k][COORD_WIDTH-1];
         if (lies_behind(k, sx ? w.px : w.hx, sy ? w.py : w.hy, sz ? w.pz : w.hz, '0))
            return VERDICT_OUTSIDE;
         if (lies_behind(k, sx ? w.hx : w.px, sy ? w.hy : w.py, sz ? w.hz : w.pz, '0))
            crossing = 1'b1;
      end
      return crossing ? VERDICT_CROSS : VERDICT_INSIDE;
   endfunction

   task automatic model_word(input cull_word_type w);
      case (w.func)
         FUNC_LOAD: begin
            if (w.slot < NUM_PLANES) begin
               plane_nx[w.slot] = w.px;
               plane_ny[w.slot] = w.py;
               plane_nz[w.slot] = w.pz;
               plane_d[w.slot] = w.sc;
               n_loads++;
               scored++;
            end else begin
               dropped++;
            end
         end
         FUNC_SPHERE: begin
            verdict_due.push_back(sphere_verdict(w));
            n_spheres++;
            scored++;
         end
         FUNC_BOX: begin
            verdict_due.push_back(box_verdict(w));
            n_boxes++;
            scored++;
         end
         default: dropped++;
      endcase
   endtask

   task automatic send_word(input cull_word_type w);
      if (gaps_on && $urandom_range(99) < 33) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_func <= w.func;
      req_plane_slot <= w.slot;
      req_point_x <= w.px;
      req_point_y <= w.py;
      req_point_z <= w.pz;
      req_far_x <= w.hx;
      req_far_y <= w.hy;
      req_far_z <= w.hz;
      req_scalar <= w.sc;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      model_word(w);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (verdict_due.size() != 0);
   endtask

   function automatic coord_type rand_coord(input int unsigned span);
      coord_type v;
      v = $urandom;
      return v >>> (32 - span);
   endfunction

   function automatic coord_type rand_normal(input int unsigned span);
      if ($urandom_range(3) == 0)
         return '0;
      return rand_coord(span);
   endfunction

   task automatic order_pair(inout coord_type lo, inout coord_type hi);
      coord_type t;
      if ($urandom_range(9) != 0 && lo > hi) begin
         t = lo;
         lo = hi;
         hi = t;
      end
   endtask

   // load all planes in random order, then a run of tests with some noise
   task automatic run_scene(input int tests);
      int unsigned nspan, pspan, dspan;
      int order [NUM_PLANES];
      int j, t, pick;
      coord_type ax, ay, az, bx, by, bz, r;
      nspan = ($urandom_range(9) == 0) ? 32 : $urandom_range(4, 19);
      pspan = ($urandom_range(9) == 0) ? 32 : $urandom_range(16, 24);
      dspan = ($urandom_range(9) == 0) ? 32 : $urandom_range(16, 24);
      for (int i = 0; i < NUM_PLANES; i++)
         order[i] = i;
      for (int i = 0; i < NUM_PLANES; i++) begin
         j = $urandom_range(i, NUM_PLANES - 1);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < NUM_PLANES; i++)
         send_word(word_of(FUNC_LOAD, SLOT_W'(order[i]), rand_normal(nspan),
                           rand_normal(nspan), rand_normal(nspan), $urandom, $urandom,
                           $urandom, rand_coord(dspan)));
      for (int i = 0; i < tests; i++) begin
         pick = $urandom_range(99);
         ax = rand_coord(pspan);
         ay = rand_coord(pspan);
         az = rand_coord(pspan);
         bx = rand_coord(pspan);
         by = rand_coord(pspan);
         bz = rand_coord(pspan);
         r = rand_coord(pspan - 2);
         if ($urandom_range(4) != 0 && r < 0)
            r = -r;
         if (pick < 5) begin
            send_word(word_of(FUNC_NOP, SLOT_W'($urandom), $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom));
         end else if (pick < 8) begin
            send_word(word_of(FUNC_LOAD, SLOT_W'($urandom_range(NUM_PLANES, 7)), $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
         end else if (pick < 12) begin
            send_word(word_of(FUNC_W'($urandom_range(FUNC_SPHERE, FUNC_BOX)),
                              SLOT_W'($urandom), $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom));
         end else if (pick < 16) begin
            send_word(word_of(FUNC_LOAD, SLOT_W'($urandom_range(NUM_PLANES - 1)),
                              rand_normal(nspan), rand_normal(nspan), rand_normal(nspan),
                              $urandom, $urandom, $urandom, rand_coord(dspan)));
         end else if (pick < 58) begin
            send_word(word_of(FUNC_SPHERE, SLOT_W'($urandom), ax, ay, az, $urandom,
                              $urandom, $urandom, r));
         end else begin
            order_pair(ax, bx);
            order_pair(ay, by);
            order_pair(az, bz);
            send_word(word_of(FUNC_BOX, SLOT_W'($urandom), ax, ay, az, bx, by, bz,
                              $urandom));
         end
      end
   endtask

   task automatic test_reset_planes();
      send_word(word_of(FUNC_SPHERE, 0, CMAX, CMAX, CMAX, 0, 0, 0, 0));
      send_word(word_of(FUNC_SPHERE, 0, CMIN, CMIN, CMIN, 0, 0, 0, CMIN));
      send_word(word_of(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0, -1));
      send_word(word_of(FUNC_BOX, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
   endtask

   task automatic test_corner_words();
      // slab -10 <= x <= 10; other planes stay zero
      send_word(word_of(FUNC_LOAD, 0, ONE, 0, 0, 0, 0, 0, -10 * ONE));
      send_word(word_of(FUNC_LOAD, 1, -ONE, 0, 0, 0, 0, 0, -10 * ONE));
      send_word(word_of(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0, ONE));
      send_word(word_of(FUNC_SPHERE, 0, -12 * ONE, 0, 0, 0, 0, 0, ONE));
      send_word(word_of(FUNC_SPHERE, 0, -12 * ONE, 0, 0, 0, 0, 0, 3 * ONE));
      send_word(word_of(FUNC_SPHERE, 0, -11 * ONE, 0, 0, 0, 0, 0, ONE));
      send_word(word_of(FUNC_BOX, 0, -5 * ONE, -5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE,
                        5 * ONE, 0));
      send_word(word_of(FUNC_BOX, 0, -15 * ONE, 0, 0, -11 * ONE, ONE, ONE, 0));
      send_word(word_of(FUNC_BOX, 0, -15 * ONE, 0, 0, 0, ONE, ONE, 0));
      send_word(word_of(FUNC_BOX, 0, 5 * ONE, ONE, ONE, -5 * ONE, 0, 0, 0));
      send_word(word_of(FUNC_NOP, 7, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
      send_word(word_of(FUNC_LOAD, 6, CMIN, CMIN, CMIN, 0, 0, 0, CMAX));
      send_word(word_of(FUNC_LOAD, 7, CMIN, CMIN, CMIN, 0, 0, 0, CMAX));
      send_word(word_of(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0, ONE));
      send_word(word_of(FUNC_LOAD, 5, CMIN, CMIN, CMIN, 0, 0, 0, CMAX));
      send_word(word_of(FUNC_SPHERE, 0, CMIN, CMIN, CMIN, 0, 0, 0, CMAX));
      send_word(word_of(FUNC_BOX, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
      send_word(word_of(FUNC_LOAD, 4, CMAX, 0, CMAX, 0, 0, 0, CMIN));
      send_word(word_of(FUNC_SPHERE, 0, CMAX, CMAX, CMAX, 0, 0, 0, CMAX));
      send_word(word_of(FUNC_BOX, 0, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0));
      send_word(word_of(FUNC_LOAD, 5, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_steady_stream();
      gaps_on = 1'b0;
      run_scene(150);
      gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      run_scene(12);
      wait_drained();
      run_scene(12);
   endtask

   task automatic test_random_scenes();
      while (scored < ITEMS_TARGET)
         run_scene($urandom_range(10, 40));
   endtask

   always @(posedge clock) begin : check_verdicts
      logic [VERDICT_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (verdict_due.size() == 0) begin
            $error("verdict: expected none, got %0d", rsp_verdict);
            fails++;
         end else begin
            want = verdict_due.pop_front();
            if (rsp_verdict !== want) begin
               $error("verdict: expected %0d, got %0d", want, rsp_verdict);
               fails++;
            end
            if (want <= VERDICT_OUTSIDE)
               verdict_seen[want]++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < NUM_PLANES; k++) begin
         plane_nx[k] = '0;
         plane_ny[k] = '0;
         plane_nz[k] = '0;
         plane_d[k] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_planes();
      test_corner_words();
      test_drain_pause();
      test_steady_stream();
      test_random_scenes();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d plane loads, %0d sphere tests, %0d box tests, %0d dropped words",
               n_loads, n_spheres, n_boxes, dropped);
      $display("verdicts: %0d inside or kept, %0d crossing, %0d outside or culled",
               verdict_seen[0], verdict_seen[1], verdict_seen[2]);
      if (fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
